>>> src/mie_pkg.sv
// Shared types and constants for the MIPS integer execute unit.
// No dependencies; imported by mie_ram users and the top level.
package mie_pkg;

   localparam int DATA_W     = 32;
   localparam int REG_COUNT  = 32;
   localparam int REG_ADDR_W = $clog2(REG_COUNT);
   localparam logic [REG_ADDR_W-1:0] ITER_LAST = REG_ADDR_W'(DATA_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } state_type;

   // opcodes
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;

   // funct codes for SPECIAL
   localparam logic [5:0] FN_SLL   = 6'd0;
   localparam logic [5:0] FN_SRL   = 6'd2;
   localparam logic [5:0] FN_SRA   = 6'd3;
   localparam logic [5:0] FN_SLLV  = 6'd4;
   localparam logic [5:0] FN_SRLV  = 6'd6;
   localparam logic [5:0] FN_SRAV  = 6'd7;
   localparam logic [5:0] FN_JR    = 6'd8;
   localparam logic [5:0] FN_JALR  = 6'd9;
   localparam logic [5:0] FN_MFHI  = 6'd16;
   localparam logic [5:0] FN_MFLO  = 6'd18;
   localparam logic [5:0] FN_MTLO  = 6'd19;
   localparam logic [5:0] FN_MULT  = 6'd24;
   localparam logic [5:0] FN_MULTU = 6'd25;
   localparam logic [5:0] FN_DIV   = 6'd26;
   localparam logic [5:0] FN_DIVU  = 6'd27;
   localparam logic [5:0] FN_ADD   = 6'd32;
   localparam logic [5:0] FN_ADDU  = 6'd33;
   localparam logic [5:0] FN_SUB   = 6'd34;
   localparam logic [5:0] FN_SUBU  = 6'd35;
   localparam logic [5:0] FN_AND   = 6'd36;
   localparam logic [5:0] FN_OR    = 6'd37;
   localparam logic [5:0] FN_XOR   = 6'd38;
   localparam logic [5:0] FN_NOR   = 6'd39;
   localparam logic [5:0] FN_SLT   = 6'd42;
   localparam logic [5:0] FN_SLTU  = 6'd43;

endpackage

>>> src/mie_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

>>> src/mips_integer_execute_unit.sv
// MIPS-I integer execute unit: register file, HI/LO, sequencer and datapath.
// Depends on mie_pkg and mie_ram.
//
// Usage: one instruction word and its PC arrive on the req_ channel; one
// result transaction (next PC, redirect, register write, fault flags) leaves
// on the rsp_ channel. Both channels use valid/stall; a transaction moves on
// an edge with valid high and stall low.
// The block works on one instruction at a time and stalls req_ meanwhile.
// From acceptance to rsp_valid, ALU, shift, branch and jump instructions pass
// register read, execute and output load. mult/multu and div/divu run 32
// iterations of a shared 33-bit add/subtract unit, one bit a cycle, plus a
// sign fix step, before the output load. Division by zero skips the loop.
// A new instruction is accepted the cycle after its predecessor's result is
// loaded into the output register, even while that result is still stalled.
// A stalled rsp_ holds the result; a finished instruction waits in the
// sequencer until the output register is free.
// Reset (synchronous, active high) empties the output register, returns the
// sequencer to idle and clears HI, LO and the register file valid bits, so
// every register reads zero right away. Register zero always reads zero.
module mips_integer_execute_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_instr_word,
   input  logic [31:0]                req_pc_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_next_pc,
   output logic                       rsp_redirected,
   output logic                       rsp_reg_written,
   output logic [mie_pkg::REG_ADDR_W-1:0] rsp_dest_index,
   output logic [31:0]                rsp_dest_value,
   output logic                       rsp_overflow_fault,
   output logic                       rsp_unsupported_op
);
   import mie_pkg::*;

   state_type state_ff, state_in;

   logic [31:0] instr_ff, instr_in;
   logic [31:0] pc_ff, pc_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;

   // iteration registers
   logic [31:0] acc_hi_ff, acc_hi_in, acc_lo_ff, acc_lo_in, opb_ff, opb_in;
   logic [REG_ADDR_W-1:0] cnt_ff, cnt_in;
   logic neg_lo_ff, neg_lo_in, neg_hi_ff, neg_hi_in, div_mode_ff, div_mode_in;

   // staged result
   logic [31:0] res_npc_ff, res_npc_in, res_dv_ff, res_dv_in;
   logic [REG_ADDR_W-1:0] res_di_ff, res_di_in;
   logic res_redir_ff, res_redir_in, res_wr_ff, res_wr_in;
   logic res_ovf_ff, res_ovf_in, res_bad_ff, res_bad_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_npc_ff, out_npc_in, out_dv_ff, out_dv_in;
   logic [REG_ADDR_W-1:0] out_di_ff, out_di_in;
   logic out_redir_ff, out_redir_in, out_wr_ff, out_wr_in;
   logic out_ovf_ff, out_ovf_in, out_bad_ff, out_bad_in;

   logic req_take, out_free, ram_wr_en;
   logic [31:0] ram_q_a, ram_q_b;

   // decode
   logic [5:0] op, fn;
   logic [REG_ADDR_W-1:0] rs, rt, rd, sa;
   logic [15:0] imm;
   logic [31:0] a, b, seq, simm;
   logic is_mul, is_div;

   // shared add/subtract unit
   logic [32:0] add_x, add_y;
   logic        add_sub;
   logic [33:0] add_res;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_wr_en = (state_ff == ST_DONE) && out_free && res_wr_ff;

   mie_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_regfile (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (res_di_ff),
      .wr_data   (res_dv_ff),
      .rd_addr_a (req_instr_word[25:21]),
      .rd_addr_b (req_instr_word[20:16]),
      .rd_data_a (ram_q_a),
      .rd_data_b (ram_q_b)
   );

   assign op   = instr_ff[31:26];
   assign rs   = instr_ff[25:21];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sa   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign imm  = instr_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign seq  = pc_ff + 32'd4;
   // entries never written since reset read as zero
   assign a = valid_ff[rs] ? ram_q_a : '0;
   assign b = valid_ff[rt] ? ram_q_b : '0;

   assign is_mul = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
   assign is_div = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU) && (b != '0);

   always_comb begin
      if (state_ff == ST_DIV) begin
         add_x   = {acc_hi_ff, acc_lo_ff[31]};
         add_y   = {1'b0, opb_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = {1'b0, acc_hi_ff};
         add_y   = acc_lo_ff[0] ? {1'b0, opb_ff} : '0;
         add_sub = 1'b0;
      end
      add_res = add_sub ? ({1'b0, add_x} - {1'b0, add_y})
                        : ({1'b0, add_x} + {1'b0, add_y});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_EXEC;
         ST_EXEC: begin
            if (is_mul)      state_in = ST_MUL;
            else if (is_div) state_in = ST_DIV;
            else             state_in = ST_DONE;
         end
         ST_MUL:  if (cnt_ff == ITER_LAST) state_in = ST_FIX;
         ST_DIV:  if (cnt_ff == ITER_LAST) state_in = ST_FIX;
         ST_FIX:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [31:0] npc, dv, r, ma, mb;
      logic        redir, wr, ovf, bad, take, sgn, na, nb;
      logic [REG_ADDR_W-1:0] di;
      logic [63:0] prod;

      instr_in = instr_ff;  pc_in = pc_ff;
      valid_in = valid_ff;  hi_in = hi_ff;  lo_in = lo_ff;
      acc_hi_in = acc_hi_ff; acc_lo_in = acc_lo_ff; opb_in = opb_ff;
      cnt_in = cnt_ff; neg_lo_in = neg_lo_ff; neg_hi_in = neg_hi_ff;
      div_mode_in = div_mode_ff;
      res_npc_in = res_npc_ff; res_dv_in = res_dv_ff; res_di_in = res_di_ff;
      res_redir_in = res_redir_ff; res_wr_in = res_wr_ff;
      res_ovf_in = res_ovf_ff; res_bad_in = res_bad_ff;
      out_npc_in = out_npc_ff; out_dv_in = out_dv_ff; out_di_in = out_di_ff;
      out_redir_in = out_redir_ff; out_wr_in = out_wr_ff;
      out_ovf_in = out_ovf_ff; out_bad_in = out_bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      npc = seq; dv = '0; r = '0; redir = 1'b0; wr = 1'b0; ovf = 1'b0;
      bad = 1'b0; take = 1'b0; di = '0; prod = '0;
      sgn = (fn == FN_MULT) || (fn == FN_DIV);
      na = sgn && a[31];
      nb = sgn && b[31];
      ma = na ? (32'd0 - a) : a;
      mb = nb ? (32'd0 - b) : b;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               instr_in = req_instr_word;
               pc_in    = req_pc_value;
            end
         end
         ST_EXEC: begin
            if (op == OP_SPECIAL) begin
               wr = 1'b1;
               di = rd;
               case (fn)
                  FN_SLL:  dv = b << sa;
                  FN_SRL:  dv = b >> sa;
                  FN_SRA:  dv = 32'($signed(b) >>> sa);
                  FN_SLLV: dv = b << a[4:0];
                  FN_SRLV: dv = b >> a[4:0];
                  FN_SRAV: dv = 32'($signed(b) >>> a[4:0]);
                  FN_JR: begin
                     wr = 1'b0; npc = a; redir = 1'b1;
                  end
                  FN_JALR: begin
                     dv = seq; npc = a; redir = 1'b1;
                  end
                  FN_MFHI: dv = hi_ff;
                  FN_MFLO: dv = lo_ff;
                  FN_MTLO: begin
                     wr = 1'b0; lo_in = a;
                  end
                  FN_MULT, FN_MULTU: begin
                     wr = 1'b0;
                     acc_hi_in = '0; acc_lo_in = mb; opb_in = ma;
                     neg_lo_in = na ^ nb; div_mode_in = 1'b0; cnt_in = '0;
                  end
                  FN_DIV, FN_DIVU: begin
                     wr = 1'b0;
                     acc_hi_in = '0; acc_lo_in = ma; opb_in = mb;
                     neg_lo_in = na ^ nb; neg_hi_in = na;
                     div_mode_in = 1'b1; cnt_in = '0;
                  end
                  FN_ADD: begin
                     r = a + b;
                     if (((a ^ r) & (b ^ r) & 32'h8000_0000) != '0) begin
                        ovf = 1'b1; wr = 1'b0;
                     end else dv = r;
                  end
                  FN_SUB: begin
                     r = a - b;
                     if (((a ^ b) & (a ^ r) & 32'h8000_0000) != '0) begin
                        ovf = 1'b1; wr = 1'b0;
                     end else dv = r;
                  end
                  FN_ADDU: dv = a + b;
                  FN_SUBU: dv = a - b;
                  FN_AND:  dv = a & b;
                  FN_OR:   dv = a | b;
                  FN_XOR:  dv = a ^ b;
                  FN_NOR:  dv = ~(a | b);
                  FN_SLT:  dv = {31'd0, $signed(a) < $signed(b)};
                  FN_SLTU: dv = {31'd0, a < b};
                  default: begin
                     wr = 1'b0; bad = 1'b1;
                  end
               endcase
            end else begin
               di = rt;
               case (op)
                  OP_BEQ:  take = (a == b);
                  OP_BNE:  take = (a != b);
                  OP_BLEZ: take = (a == '0) || a[31];
                  OP_BGTZ: take = (a != '0) && !a[31];
                  OP_ADDI: begin
                     r = a + simm;
                     if (((a ^ r) & (simm ^ r) & 32'h8000_0000) != '0) ovf = 1'b1;
                     else begin
                        wr = 1'b1; dv = r;
                     end
                  end
                  OP_ADDIU: begin wr = 1'b1; dv = a + simm; end
                  OP_SLTI:  begin wr = 1'b1; dv = {31'd0, $signed(a) < $signed(simm)}; end
                  OP_SLTIU: begin wr = 1'b1; dv = {31'd0, a < simm}; end
                  OP_ANDI:  begin wr = 1'b1; dv = a & {16'd0, imm}; end
                  OP_ORI:   begin wr = 1'b1; dv = a | {16'd0, imm}; end
                  OP_XORI:  begin wr = 1'b1; dv = a ^ {16'd0, imm}; end
                  OP_LUI:   begin wr = 1'b1; dv = {imm, 16'd0}; end
                  default:  bad = 1'b1;
               endcase
               if (take) begin
                  npc = seq + {simm[29:0], 2'b00};
                  redir = 1'b1;
               end
            end
            // writes to register zero are dropped and reported as none
            if (!wr || di == '0) begin
               wr = 1'b0; di = '0; dv = '0;
            end
            res_npc_in = npc; res_redir_in = redir; res_wr_in = wr;
            res_di_in = di; res_dv_in = dv; res_ovf_in = ovf; res_bad_in = bad;
         end
         ST_MUL: begin
            acc_hi_in = add_res[32:1];
            acc_lo_in = {add_res[0], acc_lo_ff[31:1]};
            cnt_in    = cnt_ff + 1'b1;
         end
         ST_DIV: begin
            if (!add_res[33]) begin
               acc_hi_in = add_res[31:0];
               acc_lo_in = {acc_lo_ff[30:0], 1'b1};
            end else begin
               acc_hi_in = add_x[31:0];
               acc_lo_in = {acc_lo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         ST_FIX: begin
            if (div_mode_ff) begin
               lo_in = neg_lo_ff ? (32'd0 - acc_lo_ff) : acc_lo_ff;
               hi_in = neg_hi_ff ? (32'd0 - acc_hi_ff) : acc_hi_ff;
            end else begin
               prod = neg_lo_ff ? (64'd0 - {acc_hi_ff, acc_lo_ff})
                                : {acc_hi_ff, acc_lo_ff};
               hi_in = prod[63:32];
               lo_in = prod[31:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_npc_in = res_npc_ff; out_redir_in = res_redir_ff;
               out_wr_in = res_wr_ff; out_di_in = res_di_ff; out_dv_in = res_dv_ff;
               out_ovf_in = res_ovf_ff; out_bad_in = res_bad_ff;
               if (res_wr_ff) valid_in[res_di_ff] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      instr_ff <= instr_in;  pc_ff <= pc_in;
      acc_hi_ff <= acc_hi_in; acc_lo_ff <= acc_lo_in; opb_ff <= opb_in;
      cnt_ff <= cnt_in; neg_lo_ff <= neg_lo_in; neg_hi_ff <= neg_hi_in;
      div_mode_ff <= div_mode_in;
      res_npc_ff <= res_npc_in; res_dv_ff <= res_dv_in; res_di_ff <= res_di_in;
      res_redir_ff <= res_redir_in; res_wr_ff <= res_wr_in;
      res_ovf_ff <= res_ovf_in; res_bad_ff <= res_bad_in;
      out_npc_ff <= out_npc_in; out_dv_ff <= out_dv_in; out_di_ff <= out_di_in;
      out_redir_ff <= out_redir_in; out_wr_ff <= out_wr_in;
      out_ovf_ff <= out_ovf_in; out_bad_ff <= out_bad_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = out_npc_ff;
   assign rsp_redirected     = out_redir_ff;
   assign rsp_reg_written    = out_wr_ff;
   assign rsp_dest_index     = out_di_ff;
   assign rsp_dest_value     = out_dv_ff;
   assign rsp_overflow_fault = out_ovf_ff;
   assign rsp_unsupported_op = out_bad_ff;

   a_take_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter execute");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> res_di_ff != '0)
      else $error("register zero written");

   a_r0_invalid: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0])
      else $error("register zero marked valid");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_overflow_fault || rsp_unsupported_op) |-> !rsp_reg_written)
      else $error("faulting instruction reported a write");

endmodule

>>> tb/tb_mips_integer_execute_unit.sv
// Self-checking testbench for mips_integer_execute_unit: directed and random instruction
// streams, predicted results checked in order. Depends on mie_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_mips_integer_execute_unit;
   import mie_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        redirected;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        overflow_fault;
      logic        unsupported_op;
   } exec_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_pc_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_redirected;
   logic        rsp_reg_written;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic        rsp_overflow_fault;
   logic        rsp_unsupported_op;

   mips_integer_execute_unit DUT (.*);

   // shadow architectural state
   logic [31:0] gpr [32];
   logic [31:0] hi_shadow, lo_shadow;

   exec_result_type pending_results [$];
   int mismatch_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;
   bit random_idle = 1'b1;
   int rsp_wait_left = 0;

   initial forever #1 clock = ~clock;

   function automatic exec_result_type execute_instr(logic [31:0] iw, logic [31:0] pc);
      exec_result_type r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] a, b, imm, simm, seq, sum;
      logic [63:0] prod;
      logic [31:0] ma, mb, q, rem;
      bit          wr, take;
      op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11];
      sa = iw[10:6]; fn = iw[5:0];
      imm = {16'h0, iw[15:0]};
      simm = {{16{iw[15]}}, iw[15:0]};
      a = gpr[rs]; b = gpr[rt];
      seq = pc + 32'd4;
      r = '0;
      r.next_pc = seq;
      wr = 1'b0;
      take = 1'b0;
      if (op == OP_SPECIAL) begin
         wr = 1'b1;
         r.dest_index = rd;
         case (fn)
            FN_SLL:  r.dest_value = b << sa;
            FN_SRL:  r.dest_value = b >> sa;
            FN_SRA:  r.dest_value = $signed(b) >>> sa;
            FN_SLLV: r.dest_value = b << a[4:0];
            FN_SRLV: r.dest_value = b >> a[4:0];
            FN_SRAV: r.dest_value = $signed(b) >>> a[4:0];
            FN_JR: begin
               wr = 1'b0; r.next_pc = a; r.redirected = 1'b1;
            end
            FN_JALR: begin
               r.dest_value = seq; r.next_pc = a; r.redirected = 1'b1;
            end
            FN_MFHI: r.dest_value = hi_shadow;
            FN_MFLO: r.dest_value = lo_shadow;
            FN_MTLO: begin
               wr = 1'b0; lo_shadow = a;
            end
            FN_MULT, FN_MULTU: begin
               if (fn == FN_MULT)
                  prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               else
                  prod = {32'h0, a} * {32'h0, b};
               hi_shadow = prod[63:32];
               lo_shadow = prod[31:0];
               wr = 1'b0;
            end
            FN_DIV, FN_DIVU: begin
               wr = 1'b0;
               if (b != 0) begin
                  if (fn == FN_DIVU) begin
                     lo_shadow = a / b;
                     hi_shadow = a % b;
                  end else begin
                     ma = a[31] ? -a : a;
                     mb = b[31] ? -b : b;
                     q = ma / mb;
                     rem = ma % mb;
                     lo_shadow = (a[31] != b[31]) ? -q : q;
                     hi_shadow = a[31] ? -rem : rem;
                  end
               end
            end
            FN_ADD, FN_SUB: begin
               sum = (fn == FN_ADD) ? a + b : a - b;
               if (fn == FN_ADD ? ((a ^ sum) & (b ^ sum)) >> 31 : ((a ^ b) & (a ^ sum)) >> 31)
               begin
                  r.overflow_fault = 1'b1; wr = 1'b0;
               end else
                  r.dest_value = sum;
            end
            FN_ADDU: r.dest_value = a + b;
            FN_SUBU: r.dest_value = a - b;
            FN_AND:  r.dest_value = a & b;
            FN_OR:   r.dest_value = a | b;
            FN_XOR:  r.dest_value = a ^ b;
            FN_NOR:  r.dest_value = ~(a | b);
            FN_SLT:  r.dest_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_SLTU: r.dest_value = (a < b) ? 32'd1 : 32'd0;
            default: begin
               wr = 1'b0; r.unsupported_op = 1'b1;
            end
         endcase
      end else begin
         r.dest_index = rt;
         case (op)
            OP_BEQ:  take = (a == b);
            OP_BNE:  take = (a != b);
            OP_BLEZ: take = ($signed(a) <= 0);
            OP_BGTZ: take = ($signed(a) > 0);
            OP_ADDI: begin
               sum = a + simm;
               if (((a ^ sum) & (simm ^ sum)) >> 31)
                  r.overflow_fault = 1'b1;
               else begin
                  wr = 1'b1; r.dest_value = sum;
               end
            end
            OP_ADDIU: begin wr = 1'b1; r.dest_value = a + simm; end
            OP_SLTI: begin
               wr = 1'b1; r.dest_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            end
            OP_SLTIU: begin wr = 1'b1; r.dest_value = (a < simm) ? 32'd1 : 32'd0; end
            OP_ANDI: begin wr = 1'b1; r.dest_value = a & imm; end
            OP_ORI:  begin wr = 1'b1; r.dest_value = a | imm; end
            OP_XORI: begin wr = 1'b1; r.dest_value = a ^ imm; end
            OP_LUI:  begin wr = 1'b1; r.dest_value = imm << 16; end
            default: r.unsupported_op = 1'b1;
         endcase
         if (take) begin
            r.next_pc = seq + (simm << 2);
            r.redirected = 1'b1;
         end
      end
      if (!wr || r.dest_index == 0) begin
         r.dest_index = '0;
         r.dest_value = '0;
      end else begin
         r.reg_written = 1'b1;
         gpr[r.dest_index] = r.dest_value;
      end
      return r;
   endfunction

   // one transaction on req_, with a random lead-in gap when random_idle is set
   task automatic send_instr(input logic [31:0] iw, input logic [31:0] pc);
      int gap;
      gap = random_idle ? $urandom_range(16, 0) : 0;
      if (random_idle && $urandom_range(3, 0) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_instr_word <= iw;
      req_pc_value <= pc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(execute_instr(iw, pc));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] rand_word;
      return $urandom;
   endfunction

   // receiver wait: a fresh count of stall cycles is drawn for every result
   always @(posedge clock) begin
      if (reset)
         rsp_wait_left <= 0;
      else if (rsp_valid && !rsp_stall)
         rsp_wait_left <= $urandom_range(16, 0);
      else if (rsp_stall && rsp_wait_left > 0)
         rsp_wait_left <= rsp_wait_left - 1;
   end

   // receiver: per-result stalls plus a long forced hold
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_rsp)
         rsp_stall <= 1'b1;
      else if (random_idle)
         rsp_stall <= (rsp_wait_left > 0);
      else
         rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      exec_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_next_pc, rsp_redirected, rsp_reg_written, rsp_dest_index,
                 rsp_dest_value, rsp_overflow_fault, rsp_unsupported_op};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: result %0d expected %p got %p", checked_count, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout with %0d results outstanding", pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // register setup, a selection of operations, faults, field extremes
   task automatic test_directed;
      logic [31:0] pc;
      pc = 32'h0040_0000;
      send_instr(i_word(OP_LUI, 5'd0, 5'd1, 16'h8000), pc);         // r1 = 0x80000000
      send_instr(i_word(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF), pc + 4);    // r2 = -1
      send_instr(i_word(OP_ORI, 5'd0, 5'd3, 16'hFFFF), pc + 8);
      send_instr(i_word(OP_LUI, 5'd0, 5'd4, 16'h7FFF), pc + 12);
      send_instr(i_word(OP_ORI, 5'd4, 5'd4, 16'hFFFF), pc + 16);     // r4 = max int
      send_instr(r_word(FN_ADD, 5'd4, 5'd4, 5'd5, 5'd0), pc + 20);    // overflow
      send_instr(r_word(FN_SUB, 5'd1, 5'd4, 5'd5, 5'd0), pc + 24);    // overflow
      send_instr(i_word(OP_ADDI, 5'd4, 5'd5, 16'h0001), pc + 28);    // overflow
      send_instr(r_word(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0), pc + 32);    // min / -1
      send_instr(r_word(FN_MFLO, 5'd0, 5'd0, 5'd6, 5'd0), pc + 36);
      send_instr(r_word(FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0), pc + 40);
      send_instr(r_word(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0), pc + 44);   // divide by zero
      send_instr(r_word(FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0), pc + 48);
      send_instr(r_word(FN_MULT, 5'd1, 5'd1, 5'd0, 5'd0), pc + 52);
      send_instr(r_word(FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0), pc + 56);
      send_instr(r_word(FN_MFHI, 5'd0, 5'd0, 5'd0, 5'd0), pc + 60);   // write to r0
      send_instr(r_word(FN_SRA, 5'd0, 5'd1, 5'd9, 5'd31), pc + 64);
      send_instr(r_word(FN_SRLV, 5'd2, 5'd1, 5'd9, 5'd0), pc + 68);
      send_instr(i_word(OP_BLEZ, 5'd0, 5'd0, 16'h8000), 32'hFFFF_FFFC);
      send_instr(i_word(OP_BGTZ, 5'd4, 5'd0, 16'h7FFF), pc + 72);
      send_instr(r_word(FN_JALR, 5'd9, 5'd0, 5'd9, 5'd0), pc + 76);   // rs read before write
      send_instr(r_word(FN_MTLO, 5'd4, 5'd0, 5'd0, 5'd0), pc + 80);
      send_instr(i_word(6'd2, 5'd1, 5'd2, 16'h1234), pc + 84);        // j: unsupported
      send_instr(r_word(6'd13, 5'd1, 5'd2, 5'd3, 5'd0), pc + 88);     // break: unsupported
      drain_results();
   endtask

   task automatic send_random_instr;
      logic [31:0] iw;
      logic [5:0]  fns [26];
      logic [5:0]  ops [12];
      int k;
      fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_MFHI,
              FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
              FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_ADD};
      ops = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
              OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
      iw = rand_word();
      k = $urandom_range(9, 0);
      if (k < 5) begin
         iw[31:26] = OP_SPECIAL;
         iw[5:0] = fns[$urandom_range(25, 0)];
         // mul/div are slow; keep mult and div less frequent
         if ((iw[5:0] == FN_MULT || iw[5:0] == FN_DIV) && $urandom_range(1, 0)) iw[5:0] = FN_OR;
      end else if (k < 9)
         iw[31:26] = ops[$urandom_range(11, 0)];
      send_instr(iw, rand_word());
   endtask

   task automatic test_random;
      repeat (800) send_random_instr();
      drain_results();
   endtask

   // receiver held off for a long stretch while instructions keep being offered
   task automatic test_backpressure;
      fork
         begin
            hold_rsp = 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 200) begin
               @(posedge clock);
               hold_cycles++;
            end
            hold_rsp = 1'b0;
         end
         repeat (20) send_random_instr();
      join
      drain_results();
   endtask

   // back-to-back with no idling on either side
   task automatic test_streaming;
      random_idle = 1'b0;
      repeat (100) send_random_instr();
      drain_results();
      random_idle = 1'b1;
   endtask

   initial begin
      foreach (gpr[i]) gpr[i] = '0;
      hi_shadow = '0;
      lo_shadow = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random();
      test_backpressure();
      test_streaming();
      repeat (50) @(negedge clock);
      $display("Sent %0d instructions, checked %0d results, %0d mismatches",
               sent_count, checked_count, mismatch_count);
      $display("Covered all ops, faults, division corners, and both-side stalls");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/mie_pkg.sv
src/mie_ram.sv
src/mips_integer_execute_unit.sv
tb/tb_mips_integer_execute_unit.sv
